/* hw/rtl/rrts_pkg.sv */
package rrts_pkg;

  typedef enum logic [3:0] {
    FN_TICK     = 4'd0,
    FN_ADD      = 4'd1,
    FN_REMOVE   = 4'd2,
    FN_YIELD    = 4'd3,
    FN_START    = 4'd4,
    FN_MINIT    = 4'd5,
    FN_MLOCK    = 4'd6,
    FN_MTRY     = 4'd7,
    FN_MREL     = 4'd8,
    FN_SINIT    = 4'd9,
    FN_SGET     = 4'd10,
    FN_STRY     = 4'd11,
    FN_SPUT     = 4'd12,
    FN_NOP13    = 4'd13,
    FN_NOP14    = 4'd14,
    FN_NOP15    = 4'd15
  } func_e;

  localparam logic [1:0] ST_FREE    = 2'd0;
  localparam logic [1:0] ST_WAIT    = 2'd1;
  localparam logic [1:0] ST_READY   = 2'd2;
  localparam logic [1:0] ST_BLOCKED = 2'd3;

  localparam int unsigned FuncW = 4;
  localparam int unsigned ObjW  = 2;
  localparam int unsigned InitW = 8;
  localparam int unsigned TickW = 16;

  typedef struct packed {
    logic [3:0] func;
    logic [1:0] obj;
    logic [7:0] initv;
  } call_t;

endpackage

/* hw/rtl/round_robin_task_scheduler.sv */
// Each call passes the exec and done states; add and a schedule also search,
// one slot per cycle (round robin for a schedule, upward from slot 0 for add).
// A call is taken only in idle; a two-entry queue holds calls meanwhile.
// Reset: all slots free, all mutexes locked, tick counter and reload at 100.
module round_robin_task_scheduler #(
  parameter int unsigned MAX_TASKS = 8,
  parameter int unsigned NUM_MUTEXES = 4,
  parameter int unsigned NUM_SEMAPHORES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[3:0], object_index[5:4], init_value[13:6], zeros
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // running_task[2:0], switched[3], granted[4], idle[5], new_slot[8:6],
  // table_full[9], zeros
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import rrts_pkg::*;

  call_t       call, qcall;
  logic        qv, qr, busy;
  logic [9:0]  res;
  logic [15:0] reload_q;

  assign call = '{func: s_axis_tdata[3:0], obj: s_axis_tdata[5:4],
                  initv: s_axis_tdata[13:6]};
  assign cfg_ready_o = !busy && !qv;
  assign m_axis_tdata = {6'd0, res};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reload_q <= 16'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      reload_q <= cfg_data_i;
    end
  end

  rrts_front u_front (
    .clk_i, .rst_ni, .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .call_i(call), .q_valid_o(qv), .q_ready_i(qr), .q_call_o(qcall)
  );

  rrts_back #(.MaxTasks(MAX_TASKS), .NumMutexes(NUM_MUTEXES), .NumSems(NUM_SEMAPHORES))
  u_back (
    .clk_i, .rst_ni, .q_valid_i(qv), .q_ready_o(qr), .q_call_i(qcall),
    .tick_reload_i(reload_q), .busy_o(busy), .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready), .res_o(res)
  );
endmodule

/* hw/rtl/rrts_front.sv */
module rrts_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  rrts_pkg::call_t      call_i,
  output logic                 q_valid_o,
  input  logic                 q_ready_i,
  output rrts_pkg::call_t      q_call_o
);
  import rrts_pkg::*;

  call_t      mem_q [2];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign ready_o   = (cnt_q != 2'd2);
  assign push      = valid_i && ready_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign pop       = q_valid_o && q_ready_i;
  assign q_call_o  = mem_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= call_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push) else $error("push into full queue");
endmodule

/* hw/rtl/rrts_back.sv */
module rrts_back #(
  parameter int unsigned MaxTasks = 8,
  parameter int unsigned NumMutexes = 4,
  parameter int unsigned NumSems = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  rrts_pkg::call_t      q_call_i,
  input  logic [15:0]          tick_reload_i,
  output logic                 busy_o,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output logic [9:0]           res_o
);
  import rrts_pkg::*;

  localparam int unsigned TW = $clog2(MaxTasks);
  localparam int unsigned CW = $clog2(MaxTasks + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_ADD  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]          st_q, st_d;
  logic [1:0]          ts_q [MaxTasks];
  logic [1:0]          ts_d [MaxTasks];
  logic [TW-1:0]       cur_q, cur_d, bef_q, bef_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [15:0]         tick_q, tick_d;
  logic [NumMutexes-1:0] ml_q, ml_d;
  logic [MaxTasks-1:0] mw_q [NumMutexes];
  logic [MaxTasks-1:0] mw_d [NumMutexes];
  logic [7:0]          sc_q [NumSems];
  logic [7:0]          sc_d [NumSems];
  logic [7:0]          sl_q [NumSems];
  logic [7:0]          sl_d [NumSems];
  logic [MaxTasks-1:0] sw_q [NumSems];
  logic [MaxTasks-1:0] sw_d [NumSems];
  logic [TW-1:0]       ptr_q, ptr_d;
  logic [CW-1:0]       step_q, step_d;
  logic                gr_q, gr_d, full_q, full_d;
  logic [TW-1:0]       ns_q, ns_d;
  call_t               c_q, c_d;
  logic                mok, sok;
  logic [MaxTasks-1:0] wmask;
  logic                do_sched;

  assign q_ready_o   = (st_q == S_IDLE);
  assign busy_o      = (st_q != S_IDLE);
  assign res_valid_o = (st_q == S_DONE);
  assign mok = ({30'd0, c_q.obj} < NumMutexes);
  assign sok = ({30'd0, c_q.obj} < NumSems);
  assign res_o = {full_q, 3'(ns_q), (cnt_q == '0), gr_q, (cur_q != bef_q), 3'(cur_q)};

  always_comb begin
    st_d = st_q; ts_d = ts_q; cur_d = cur_q; bef_d = bef_q; cnt_d = cnt_q;
    tick_d = tick_q; ml_d = ml_q; mw_d = mw_q; sc_d = sc_q; sl_d = sl_q;
    sw_d = sw_q; ptr_d = ptr_q; step_d = step_q; gr_d = gr_q; full_d = full_q;
    ns_d = ns_q; c_d = c_q; wmask = '0; do_sched = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          c_d = q_call_i; bef_d = cur_q; gr_d = 1'b0; full_d = 1'b0;
          ns_d = '0; st_d = S_EXEC;
        end
      end
      S_EXEC: begin
        st_d = S_DONE;
        case (c_q.func)
          FN_TICK: begin
            tick_d = tick_q - 16'd1;
            if (tick_d == 16'd0) begin
              tick_d = tick_reload_i;
              do_sched = 1'b1;
            end
          end
          FN_ADD: begin
            full_d = 1'b1; ptr_d = '0; st_d = S_ADD;
          end
          FN_REMOVE: begin
            if (ts_q[cur_q] != ST_FREE) begin
              ts_d[cur_q] = ST_FREE;
              cnt_d = cnt_q - CW'(1);
              for (int i = 0; i < NumMutexes; i++) mw_d[i][cur_q] = 1'b0;
              for (int i = 0; i < NumSems; i++) sw_d[i][cur_q] = 1'b0;
            end
            do_sched = 1'b1;
          end
          FN_YIELD: do_sched = 1'b1;
          FN_START: begin
            for (int i = 0; i < MaxTasks; i++)
              if (ts_q[i] == ST_READY) ts_d[i] = ST_WAIT;
            cur_d = '0;
            if (ts_d[0] == ST_WAIT) ts_d[0] = ST_READY;
            tick_d = tick_reload_i;
          end
          FN_MINIT: if (mok) begin
            ml_d[c_q.obj] = (c_q.initv != 8'd1);
            mw_d[c_q.obj] = '0;
          end
          FN_MLOCK, FN_MTRY: if (mok) begin
            if (!ml_q[c_q.obj]) begin
              ml_d[c_q.obj] = 1'b1; gr_d = 1'b1;
            end else if (c_q.func == FN_MLOCK && ts_q[cur_q] == ST_READY) begin
              ts_d[cur_q] = ST_BLOCKED;
              mw_d[c_q.obj][cur_q] = 1'b1;
              do_sched = 1'b1;
            end
          end
          FN_MREL: if (mok && ml_q[c_q.obj]) begin
            ml_d[c_q.obj] = 1'b0; wmask = mw_q[c_q.obj];
            mw_d[c_q.obj] = '0; gr_d = 1'b1;
          end
          FN_SINIT: if (sok) begin
            sc_d[c_q.obj] = c_q.initv; sl_d[c_q.obj] = c_q.initv;
            sw_d[c_q.obj] = '0;
          end
          FN_SGET, FN_STRY: if (sok) begin
            if (sc_q[c_q.obj] != 8'd0) begin
              sc_d[c_q.obj] = sc_q[c_q.obj] - 8'd1; gr_d = 1'b1;
            end else if (c_q.func == FN_SGET && ts_q[cur_q] == ST_READY) begin
              ts_d[cur_q] = ST_BLOCKED;
              sw_d[c_q.obj][cur_q] = 1'b1;
              do_sched = 1'b1;
            end
          end
          FN_SPUT: if (sok && sc_q[c_q.obj] < sl_q[c_q.obj]) begin
            sc_d[c_q.obj] = sc_q[c_q.obj] + 8'd1; wmask = sw_q[c_q.obj];
            sw_d[c_q.obj] = '0; gr_d = 1'b1;
          end
          default: ;
        endcase
        for (int i = 0; i < MaxTasks; i++)
          if (wmask[i] && ts_q[i] == ST_BLOCKED) ts_d[i] = ST_WAIT;
        if (do_sched && cnt_d != '0) begin
          if (ts_d[cur_q] == ST_READY) ts_d[cur_q] = ST_WAIT;
          ptr_d = (cur_q == TW'(MaxTasks - 1)) ? '0 : cur_q + TW'(1);
          step_d = '0;
          st_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (ts_q[ptr_q] == ST_WAIT) begin
          ts_d[ptr_q] = ST_READY; cur_d = ptr_q; st_d = S_DONE;
        end else if (step_q == CW'(MaxTasks - 1)) begin
          st_d = S_DONE;
        end else begin
          step_d = step_q + CW'(1);
          ptr_d = (ptr_q == TW'(MaxTasks - 1)) ? '0 : ptr_q + TW'(1);
        end
      end
      S_ADD: begin
        if (ts_q[ptr_q] == ST_FREE) begin
          ts_d[ptr_q] = ST_WAIT; cnt_d = cnt_q + CW'(1);
          ns_d = ptr_q; full_d = 1'b0; st_d = S_DONE;
        end else if (ptr_q == TW'(MaxTasks - 1)) begin
          st_d = S_DONE;
        end else begin
          ptr_d = ptr_q + TW'(1);
        end
      end
      S_DONE: if (res_ready_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; cur_q <= '0; bef_q <= '0; cnt_q <= '0;
      tick_q <= 16'd100; ml_q <= '1; ptr_q <= '0; step_q <= '0;
      gr_q <= 1'b0; full_q <= 1'b0; ns_q <= '0; c_q <= '0;
      for (int i = 0; i < MaxTasks; i++) ts_q[i] <= ST_FREE;
      for (int i = 0; i < NumMutexes; i++) mw_q[i] <= '0;
      for (int i = 0; i < NumSems; i++) begin
        sc_q[i] <= '0; sl_q[i] <= '0; sw_q[i] <= '0;
      end
    end else begin
      st_q <= st_d; ts_q <= ts_d; cur_q <= cur_d; bef_q <= bef_d;
      cnt_q <= cnt_d; tick_q <= tick_d; ml_q <= ml_d; mw_q <= mw_d;
      sc_q <= sc_d; sl_q <= sl_d; sw_q <= sw_d; ptr_q <= ptr_d;
      step_q <= step_d; gr_q <= gr_d; full_q <= full_d; ns_q <= ns_d;
      c_q <= c_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DONE && res_o[9] == 1'b1) |-> (c_q.func == FN_ADD))
    else $error("table full outside add");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MaxTasks)) else $error("task count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_SRCH) |=> (st_q == S_SRCH || st_q == S_DONE))
    else $error("search left badly");
endmodule
